FILE: design/lidar_free_space_point_transform_assert.svh
// Assertion macros for the lidar free-space point transform.
// Each macro checks a property on the rising edge of i_clk, off during reset.
`ifndef LIDAR_FREE_SPACE_POINT_TRANSFORM_ASSERT_SVH
`define LIDAR_FREE_SPACE_POINT_TRANSFORM_ASSERT_SVH

// Same-cycle implication.
`define LFSPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LFSPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/lfspt_pkg.sv
// ----------------------------------------------------------------------------
// lfspt_pkg
// Types, register codes, reset values and helpers for the lidar free-space
// point transform.
// ----------------------------------------------------------------------------
`default_nettype none

package lfspt_pkg;

    typedef logic signed [31:0] t_coord;
    typedef logic [2:0]         t_cfg_idx;

    // Register indexes of the configuration port
    localparam t_cfg_idx CFG_RESOLUTION = 3'd0;
    localparam t_cfg_idx CFG_ROT_W      = 3'd1;
    localparam t_cfg_idx CFG_ROT_X      = 3'd2;
    localparam t_cfg_idx CFG_ROT_Y      = 3'd3;
    localparam t_cfg_idx CFG_ROT_Z      = 3'd4;
    localparam t_cfg_idx CFG_SHIFT_X    = 3'd5;
    localparam t_cfg_idx CFG_SHIFT_Y    = 3'd6;
    localparam t_cfg_idx CFG_SHIFT_Z    = 3'd7;

    // Reset values: resolution about 0.2 m, identity rotation, no shift
    localparam logic [30:0] RESOLUTION_RST = 31'd13107;
    localparam t_coord      ROT_W_RST      = 32'sh4000_0000;

    // One bit of root per stage, one quotient bit per stage
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    localparam logic signed [36:0] Q30_ONE    = 37'sd1073741824;
    localparam logic signed [36:0] Q30_NEG    = -37'sd1073741824;
    localparam logic signed [63:0] DBL_ROUND  = 64'sd268435456;
    localparam logic signed [65:0] ROT_ROUND  = 66'sd536870912;
    localparam logic signed [36:0] S32_MAX    = 37'sd2147483647;
    localparam logic signed [36:0] S32_MIN    = -37'sd2147483648;

    function automatic logic [31:0] mag32(input t_coord v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic t_coord with_sign(input logic neg, input logic [31:0] m);
        with_sign = t_coord'(neg ? (~m + 32'd1) : m);
    endfunction

    function automatic t_coord sat32(input logic signed [36:0] v);
        if (v > S32_MAX) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [36:0] v);
        if (v > Q30_ONE) begin
            clamp_q30 = 32'sh4000_0000;
        end else if (v < Q30_NEG) begin
            clamp_q30 = -32'sh4000_0000;
        end else begin
            clamp_q30 = v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/lidar_free_space_point_transform.sv
// ----------------------------------------------------------------------------
// lidar_free_space_point_transform
// Turns each lidar hit into an occupied point and a free-space point on the
// same beam, both rotated by a quaternion and shifted into the world frame.
//
// Input channel: i_valid / o_stall with the point x, y, z (Q16.16). A request
// is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall. Each input request yields two output
// requests: first the occupied point (o_occupied = 1), then the free point
// (o_last_of_pair = 1).
// Order: the occupied point reaches the output register through the stages
// below; the free point follows in the cycle after the receiver takes the first.
// Throughput: a new point can enter in every cycle while the output register
// owes no result; the single output port drains one result per unstalled cycle.
// The stage chain is 3 input stages, 32 root stages, 3 scaling stages,
// 32 divider stages and 4 transform stages.
// Stall: the whole pipe holds while the output register still owes a result.
// Reset (i_rst_n low, synchronous): clears all valid bits and loads the
// identity rotation, zero shift and a 0.2 m resolution.
// Config: write registers only while the block is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_free_space_point_transform (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_we,
    input  wire lfspt_pkg::t_cfg_idx    i_cfg_idx,
    input  wire logic [31:0]            i_cfg_data,
    // input channel
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire lfspt_pkg::t_coord      i_point_x,
    input  wire lfspt_pkg::t_coord      i_point_y,
    input  wire lfspt_pkg::t_coord      i_point_z,
    // output channel
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output lfspt_pkg::t_coord           o_out_x,
    output lfspt_pkg::t_coord           o_out_y,
    output lfspt_pkg::t_coord           o_out_z,
    output logic                        o_occupied,
    output logic                        o_last_of_pair
);

`include "lidar_free_space_point_transform_assert.svh"

    localparam int NSq  = lfspt_pkg::SQRT_STEPS;
    localparam int NDiv = lfspt_pkg::DIV_STEPS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [30:0]       r_res;
    lfspt_pkg::t_coord r_rot_w, r_rot_x, r_rot_y, r_rot_z;
    lfspt_pkg::t_coord r_shift [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res      <= lfspt_pkg::RESOLUTION_RST;
            r_rot_w    <= lfspt_pkg::ROT_W_RST;
            r_rot_x    <= '0;
            r_rot_y    <= '0;
            r_rot_z    <= '0;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lfspt_pkg::CFG_RESOLUTION: r_res      <= i_cfg_data[30:0];
                lfspt_pkg::CFG_ROT_W:      r_rot_w    <= i_cfg_data;
                lfspt_pkg::CFG_ROT_X:      r_rot_x    <= i_cfg_data;
                lfspt_pkg::CFG_ROT_Y:      r_rot_y    <= i_cfg_data;
                lfspt_pkg::CFG_ROT_Z:      r_rot_z    <= i_cfg_data;
                lfspt_pkg::CFG_SHIFT_X:    r_shift[0] <= i_cfg_data;
                lfspt_pkg::CFG_SHIFT_Y:    r_shift[1] <= i_cfg_data;
                lfspt_pkg::CFG_SHIFT_Z:    r_shift[2] <= i_cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Rotation matrix: free-running three-stage chain off the config
    // registers. It settles long before any item reaches the transform.
    // ------------------------------------------------------------------
    logic signed [63:0] r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz, r_pwx, r_pwy, r_pwz;
    logic signed [34:0] r_dxx, r_dyy, r_dzz, r_dxy, r_dxz, r_dyz, r_dwx, r_dwy, r_dwz;
    logic signed [31:0] r_m [3][3];
    logic signed [36:0] w_m [3][3];

    always_ff @(posedge i_clk) begin
        r_pxx <= r_rot_x * r_rot_x;
        r_pyy <= r_rot_y * r_rot_y;
        r_pzz <= r_rot_z * r_rot_z;
        r_pxy <= r_rot_x * r_rot_y;
        r_pxz <= r_rot_x * r_rot_z;
        r_pyz <= r_rot_y * r_rot_z;
        r_pwx <= r_rot_w * r_rot_x;
        r_pwy <= r_rot_w * r_rot_y;
        r_pwz <= r_rot_w * r_rot_z;
        // doubled products in Q.30, rounded half up
        r_dxx <= 35'((r_pxx + lfspt_pkg::DBL_ROUND) >>> 29);
        r_dyy <= 35'((r_pyy + lfspt_pkg::DBL_ROUND) >>> 29);
        r_dzz <= 35'((r_pzz + lfspt_pkg::DBL_ROUND) >>> 29);
        r_dxy <= 35'((r_pxy + lfspt_pkg::DBL_ROUND) >>> 29);
        r_dxz <= 35'((r_pxz + lfspt_pkg::DBL_ROUND) >>> 29);
        r_dyz <= 35'((r_pyz + lfspt_pkg::DBL_ROUND) >>> 29);
        r_dwx <= 35'((r_pwx + lfspt_pkg::DBL_ROUND) >>> 29);
        r_dwy <= 35'((r_pwy + lfspt_pkg::DBL_ROUND) >>> 29);
        r_dwz <= 35'((r_pwz + lfspt_pkg::DBL_ROUND) >>> 29);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_m[i][j] <= lfspt_pkg::clamp_q30(w_m[i][j]);
            end
        end
    end

    always_comb begin
        w_m[0][0] = lfspt_pkg::Q30_ONE - (37'(r_dyy) + 37'(r_dzz));
        w_m[0][1] = 37'(r_dxy) - 37'(r_dwz);
        w_m[0][2] = 37'(r_dxz) + 37'(r_dwy);
        w_m[1][0] = 37'(r_dxy) + 37'(r_dwz);
        w_m[1][1] = lfspt_pkg::Q30_ONE - (37'(r_dxx) + 37'(r_dzz));
        w_m[1][2] = 37'(r_dyz) - 37'(r_dwx);
        w_m[2][0] = 37'(r_dxz) - 37'(r_dwy);
        w_m[2][1] = 37'(r_dyz) + 37'(r_dwx);
        w_m[2][2] = lfspt_pkg::Q30_ONE - (37'(r_dxx) + 37'(r_dyy));
    end

    // ------------------------------------------------------------------
    // Pipe control: every stage moves together; hold while the output
    // register still owes a result.
    // ------------------------------------------------------------------
    logic r_ov, r_phase;
    logic w_adv;

    assign w_adv   = !r_ov || (r_phase && !i_stall);
    assign o_stall = !w_adv;

    // ------------------------------------------------------------------
    // Input, squares, sum of squares
    // ------------------------------------------------------------------
    logic              r_v0, r_v1, r_v2;
    lfspt_pkg::t_coord r_p0 [3];
    lfspt_pkg::t_coord r_p1 [3];
    lfspt_pkg::t_coord r_p2 [3];
    logic [63:0]       r_sq1 [3];
    logic [63:0]       r_sum2;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p0[0] <= i_point_x;
            r_p0[1] <= i_point_y;
            r_p0[2] <= i_point_z;
            for (int i = 0; i < 3; i++) begin
                r_p1[i]  <= r_p0[i];
                r_sq1[i] <= lfspt_pkg::mag32(r_p0[i]) * lfspt_pkg::mag32(r_p0[i]);
                r_p2[i]  <= r_p1[i];
            end
            r_sum2 <= r_sq1[0] + r_sq1[1] + r_sq1[2];
        end
    end

    // ------------------------------------------------------------------
    // Beam length: one root bit per stage
    // ------------------------------------------------------------------
    logic              r_qv [NSq];
    lfspt_pkg::t_coord r_qp [NSq][3];
    logic [63:0]       r_sn [NSq];
    logic [63:0]       r_sr [NSq];
    logic [63:0]       w_sn_src [NSq];
    logic [63:0]       w_sr_src [NSq];
    logic [63:0]       w_st [NSq];
    logic [63:0]       n_sn [NSq];
    logic [63:0]       n_sr [NSq];

    always_comb begin
        w_sn_src[0] = r_sum2;
        w_sr_src[0] = '0;
        for (int k = 1; k < NSq; k++) begin
            w_sn_src[k] = r_sn[k-1];
            w_sr_src[k] = r_sr[k-1];
        end
        for (int k = 0; k < NSq; k++) begin
            w_st[k] = w_sr_src[k] + (64'd1 << (2 * (NSq - 1 - k)));
            if (w_sn_src[k] >= w_st[k]) begin
                n_sn[k] = w_sn_src[k] - w_st[k];
                n_sr[k] = (w_sr_src[k] >> 1) + (64'd1 << (2 * (NSq - 1 - k)));
            end else begin
                n_sn[k] = w_sn_src[k];
                n_sr[k] = w_sr_src[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_qp[0] <= r_p2;
            for (int k = 1; k < NSq; k++) begin
                r_qp[k] <= r_qp[k-1];
            end
            for (int k = 0; k < NSq; k++) begin
                r_sn[k] <= n_sn[k];
                r_sr[k] <= n_sr[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Scale setup: d = L - resolution, products |c|*d, rounding term L/2
    // ------------------------------------------------------------------
    logic              r_vd, r_vm, r_vn;
    lfspt_pkg::t_coord r_pd [3];
    lfspt_pkg::t_coord r_pm [3];
    lfspt_pkg::t_coord r_pn [3];
    logic [31:0]       r_lend, r_lenm, r_lenn, r_dd;
    logic              r_zd, r_zm, r_zn, r_hd, r_hm, r_hn;
    logic [63:0]       r_prod [3];
    logic [63:0]       r_num [3];
    logic [31:0]       w_len;

    assign w_len = r_sr[NSq-1][31:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pd   <= r_qp[NSq-1];
            r_lend <= w_len;
            r_zd   <= (w_len == 32'd0);
            r_hd   <= (w_len < {r_res, 1'b0});
            r_dd   <= w_len - {1'b0, r_res};

            r_pm   <= r_pd;
            r_lenm <= r_lend;
            r_zm   <= r_zd;
            r_hm   <= r_hd;
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= lfspt_pkg::mag32(r_pd[i]) * r_dd;
            end

            r_pn   <= r_pm;
            r_lenn <= r_lenm;
            r_zn   <= r_zm;
            r_hn   <= r_hm;
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= r_prod[i] + {33'd0, r_lenm[31:1]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider: three lanes, one quotient bit per stage. The quotient never
    // exceeds |c|, so the upper half of the dividend is below L.
    // ------------------------------------------------------------------
    logic              r_dv [NDiv];
    lfspt_pkg::t_coord r_dp [NDiv][3];
    logic [31:0]       r_dlen [NDiv];
    logic              r_dz [NDiv];
    logic              r_dh [NDiv];
    logic [31:0]       r_rem [NDiv][3];
    logic [31:0]       r_ql [NDiv][3];
    logic [31:0]       w_rem_src [NDiv][3];
    logic [31:0]       w_ql_src [NDiv][3];
    logic [31:0]       w_len_src [NDiv];
    logic [32:0]       w_dt [NDiv][3];
    logic              w_ge [NDiv][3];
    logic [31:0]       n_rem [NDiv][3];
    logic [31:0]       n_ql [NDiv][3];

    always_comb begin
        w_len_src[0] = r_lenn;
        for (int i = 0; i < 3; i++) begin
            w_rem_src[0][i] = r_num[i][63:32];
            w_ql_src[0][i]  = r_num[i][31:0];
        end
        for (int k = 1; k < NDiv; k++) begin
            w_len_src[k] = r_dlen[k-1];
            for (int i = 0; i < 3; i++) begin
                w_rem_src[k][i] = r_rem[k-1][i];
                w_ql_src[k][i]  = r_ql[k-1][i];
            end
        end
        for (int k = 0; k < NDiv; k++) begin
            for (int i = 0; i < 3; i++) begin
                w_dt[k][i]  = {w_rem_src[k][i], w_ql_src[k][i][31]};
                w_ge[k][i]  = (w_dt[k][i] >= {1'b0, w_len_src[k]});
                n_rem[k][i] = w_ge[k][i] ? 32'(w_dt[k][i] - {1'b0, w_len_src[k]})
                                         : w_dt[k][i][31:0];
                n_ql[k][i]  = {w_ql_src[k][i][30:0], w_ge[k][i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dp[0] <= r_pn;
            r_dz[0] <= r_zn;
            r_dh[0] <= r_hn;
            for (int k = 1; k < NDiv; k++) begin
                r_dp[k] <= r_dp[k-1];
                r_dz[k] <= r_dz[k-1];
                r_dh[k] <= r_dh[k-1];
            end
            for (int k = 0; k < NDiv; k++) begin
                r_dlen[k] <= w_len_src[k];
                r_rem[k]  <= n_rem[k];
                r_ql[k]   <= n_ql[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Free point select, then rotate both points and add the shift
    // ------------------------------------------------------------------
    logic               r_vf, r_vt1, r_vt2;
    lfspt_pkg::t_coord  r_pf [3];
    lfspt_pkg::t_coord  r_ff [3];
    lfspt_pkg::t_coord  n_ff [3];
    logic [32:0]        w_half [3];
    logic signed [63:0] r_mo [3][3];
    logic signed [63:0] r_mf [3][3];
    logic signed [65:0] r_so [3];
    logic signed [65:0] r_sf [3];
    lfspt_pkg::t_coord  r_oo [3];
    lfspt_pkg::t_coord  r_of [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_half[i] = {1'b0, lfspt_pkg::mag32(r_dp[NDiv-1][i])} + 33'd1;
            if (r_dz[NDiv-1]) begin
                n_ff[i] = '0;
            end else if (r_dh[NDiv-1]) begin
                n_ff[i] = lfspt_pkg::with_sign(r_dp[NDiv-1][i][31], w_half[i][32:1]);
            end else begin
                n_ff[i] = lfspt_pkg::with_sign(r_dp[NDiv-1][i][31], r_ql[NDiv-1][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pf <= r_dp[NDiv-1];
            r_ff <= n_ff;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_mo[i][j] <= r_m[i][j] * r_pf[j];
                    r_mf[i][j] <= r_m[i][j] * r_ff[j];
                end
                r_so[i] <= 66'(r_mo[i][0]) + 66'(r_mo[i][1]) + 66'(r_mo[i][2])
                           + lfspt_pkg::ROT_ROUND;
                r_sf[i] <= 66'(r_mf[i][0]) + 66'(r_mf[i][1]) + 66'(r_mf[i][2])
                           + lfspt_pkg::ROT_ROUND;
                r_oo[i] <= lfspt_pkg::sat32(37'(36'(r_so[i] >>> 30)) + 37'(r_shift[i]));
                r_of[i] <= lfspt_pkg::sat32(37'(36'(r_sf[i] >>> 30)) + 37'(r_shift[i]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Valid bits travel with the data
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_vd  <= 1'b0;
            r_vm  <= 1'b0;
            r_vn  <= 1'b0;
            r_vf  <= 1'b0;
            r_vt1 <= 1'b0;
            r_vt2 <= 1'b0;
            for (int k = 0; k < NSq; k++) begin
                r_qv[k] <= 1'b0;
            end
            for (int k = 0; k < NDiv; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v0    <= i_valid;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_qv[0] <= r_v2;
            for (int k = 1; k < NSq; k++) begin
                r_qv[k] <= r_qv[k-1];
            end
            r_vd    <= r_qv[NSq-1];
            r_vm    <= r_vd;
            r_vn    <= r_vm;
            r_dv[0] <= r_vn;
            for (int k = 1; k < NDiv; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_vf    <= r_dv[NDiv-1];
            r_vt1   <= r_vf;
            r_vt2   <= r_vt1;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hand out the occupied point, then the free point
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_phase <= 1'b0;
        end else if (w_adv) begin
            r_ov    <= r_vt2;
            r_phase <= 1'b0;
        end else if (!i_stall) begin
            // first result taken, advance to the free point
            r_phase <= 1'b1;
        end
    end

    assign o_valid        = r_ov;
    assign o_out_x        = r_phase ? r_of[0] : r_oo[0];
    assign o_out_y        = r_phase ? r_of[1] : r_oo[1];
    assign o_out_z        = r_phase ? r_of[2] : r_oo[2];
    assign o_occupied     = !r_phase;
    assign o_last_of_pair = r_phase;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LFSPT_ASSERT_NEXT(a_pair_follows, o_valid && !i_stall && !o_last_of_pair,
        o_valid && o_last_of_pair, "free point did not follow occupied point")
    `LFSPT_ASSERT_NOW(a_stall_only_when_owed, o_stall, o_valid,
        "input stalled with no result pending")
    `LFSPT_ASSERT_NOW(a_pair_starts_occupied, $rose(o_valid), o_occupied,
        "pair did not start with occupied point")

endmodule

`default_nettype wire

FILE: verif/tb_lidar_free_space_point_transform.sv
// ----------------------------------------------------------------------------
// tb_lidar_free_space_point_transform
// Self-checking bench for the lidar free-space point transform: random and
// directed points under several rotation/shift/resolution settings, with
// bursty input, patterned output stalls and a per-pair result predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lidar_free_space_point_transform;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES    = 120;
    localparam int WATCHDOG_MAX    = 20000;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        lfspt_pkg::t_coord x;
        lfspt_pkg::t_coord y;
        lfspt_pkg::t_coord z;
    } t_point;

    typedef struct packed {
        lfspt_pkg::t_coord x;
        lfspt_pkg::t_coord y;
        lfspt_pkg::t_coord z;
        logic              occ;
        logic              last;
    } t_world_pt;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    lfspt_pkg::t_cfg_idx i_cfg_idx;
    logic [31:0]         i_cfg_data;
    logic                i_valid;
    logic                o_stall;
    lfspt_pkg::t_coord   i_point_x, i_point_y, i_point_z;
    logic                o_valid;
    logic                i_stall;
    lfspt_pkg::t_coord   o_out_x, o_out_y, o_out_z;
    logic                o_occupied;
    logic                o_last_of_pair;

    lidar_free_space_point_transform i_dut (.*);

    // predictor copy of the registers
    logic [63:0]        res_q;
    logic signed [63:0] qw, qx, qy, qz, sh_x, sh_y, sh_z;

    t_point    pend_points[$];
    t_world_pt world_expected[$];
    int        n_errors;
    int        idle_cycles;
    bit        hold_off_req;   // receiver: hold stall for a long stretch
    bit        sender_pause;   // sender: offer nothing

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // divide by 2^k with an arithmetic shift, rounding half up
    function automatic logic signed [127:0] rnd_shift(input logic signed [127:0] v,
                                                      input int k);
        rnd_shift = (v + (128'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic logic signed [63:0] clip(input logic signed [63:0] v,
                                                input logic signed [63:0] lo,
                                                input logic signed [63:0] hi);
        clip = v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        int_sqrt = r;
    endfunction

    function automatic logic signed [63:0] dbl_prod(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        dbl_prod = 64'(rnd_shift(128'(a * b), 29));
    endfunction

    function automatic t_world_pt transform_pt(input logic signed [63:0] px,
                                               input logic signed [63:0] py,
                                               input logic signed [63:0] pz,
                                               input logic occ, input logic last);
        logic signed [63:0] m[3][3];
        logic signed [63:0] one, xx, yy, zz, xy, xz, yz, wx, wy, wz, v;
        logic signed [63:0] sh[3];
        logic signed [127:0] s;
        lfspt_pkg::t_coord r[3];
        one = 64'sd1 <<< 30;
        xx = dbl_prod(qx, qx); yy = dbl_prod(qy, qy); zz = dbl_prod(qz, qz);
        xy = dbl_prod(qx, qy); xz = dbl_prod(qx, qz); yz = dbl_prod(qy, qz);
        wx = dbl_prod(qw, qx); wy = dbl_prod(qw, qy); wz = dbl_prod(qw, qz);
        m[0][0] = one - (yy + zz); m[0][1] = xy - wz; m[0][2] = xz + wy;
        m[1][0] = xy + wz; m[1][1] = one - (xx + zz); m[1][2] = yz - wx;
        m[2][0] = xz - wy; m[2][1] = yz + wx; m[2][2] = one - (xx + yy);
        sh[0] = sh_x; sh[1] = sh_y; sh[2] = sh_z;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) m[i][j] = clip(m[i][j], -one, one);
            s = 128'(m[i][0]) * px + 128'(m[i][1]) * py + 128'(m[i][2]) * pz;
            v = 64'(rnd_shift(s, 30)) + sh[i];
            r[i] = lfspt_pkg::t_coord'(clip(v, -64'sd2147483648, 64'sd2147483647));
        end
        transform_pt = '{r[0], r[1], r[2], occ, last};
    endfunction

    // push the occupied and free-space results of one point
    task automatic predict_pair(input t_point p);
        logic signed [63:0] c[3], f[3];
        logic [63:0] mg, sq, len;
        sq = 0;
        c[0] = 64'(p.x); c[1] = 64'(p.y); c[2] = 64'(p.z);
        for (int i = 0; i < 3; i++) begin
            mg = c[i] < 0 ? -c[i] : c[i];
            sq = sq + mg * mg;
        end
        len = int_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            mg = c[i] < 0 ? -c[i] : c[i];
            if (len == 0) begin
                mg = 0;
            end else if (len < 2 * res_q) begin
                mg = (mg + 1) >> 1;
            end else begin
                // product fits in 64 bits: |c| <= 2^31, L - res < 2^32
                mg = (mg * (len - res_q) + (len >> 1)) / len;
            end
            f[i] = c[i] < 0 ? -$signed(mg) : $signed(mg);
        end
        world_expected.insert(world_expected.size(),
                              transform_pt(c[0], c[1], c[2], 1'b1, 1'b0));
        world_expected.insert(world_expected.size(),
                              transform_pt(f[0], f[1], f[2], 1'b0, 1'b1));
    endtask

    task automatic enqueue_point(input t_point p);
        pend_points.insert(pend_points.size(), p);
    endtask

    // driver: bursts with random gaps
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_point_x <= '0;
            i_point_y <= '0;
            i_point_z <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            automatic bit take = i_valid && !o_stall;
            automatic bit more;
            automatic t_point nxt;
            if (take) begin
                predict_pair('{i_point_x, i_point_y, i_point_z});
                void'(pend_points.pop_front());
            end
            if (i_valid && !take) begin
                // hold the stalled request
            end else begin
                more = pend_points.size() > 0 && !sender_pause;
                if (more && gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    more = 0;
                end else if (more && burst_left == 0) begin
                    burst_left <= $urandom_range(1, 30);
                    if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(0, 6);
                end else if (more) begin
                    burst_left <= burst_left - 1;
                end
                if (more) begin
                    nxt = pend_points[0];
                    i_point_x <= nxt.x;
                    i_point_y <= nxt.y;
                    i_point_z <= nxt.z;
                end
                i_valid <= more;
            end
        end
    end

    // receiver stall pattern: runs of stall and no-stall, plus a long hold-off
    int stall_run;
    int hold_left;
    bit hold_done;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_run <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
            if (hold_left == 1) hold_done <= 1'b1;
        end else if (hold_off_req && !hold_done) begin
            i_stall <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES;
        end else if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    i_stall <= 1'b1;
                    stall_run <= $urandom_range(0, 4);
                end
                1: begin
                    i_stall <= 1'b0;
                    stall_run <= $urandom_range(10, 60);
                end
                default: begin
                    i_stall <= ($urandom_range(0, 2) == 0);
                    stall_run <= 0;
                end
            endcase
        end
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (world_expected.size() == 0) begin
                $error("unexpected result x=%0d y=%0d z=%0d", o_out_x, o_out_y, o_out_z);
                n_errors++;
            end else begin
                automatic t_world_pt e = world_expected.pop_front();
                if (o_out_x !== e.x) begin
                    $error("out_x exp %0d got %0d", e.x, o_out_x);
                    n_errors++;
                end
                if (o_out_y !== e.y) begin
                    $error("out_y exp %0d got %0d", e.y, o_out_y);
                    n_errors++;
                end
                if (o_out_z !== e.z) begin
                    $error("out_z exp %0d got %0d", e.z, o_out_z);
                    n_errors++;
                end
                if (o_occupied !== e.occ) begin
                    $error("occupied exp %0b got %0b", e.occ, o_occupied);
                    n_errors++;
                end
                if (o_last_of_pair !== e.last) begin
                    $error("last_of_pair exp %0b got %0b", e.last, o_last_of_pair);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: cycles with no accepted request on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pend_points.size() > 0 || world_expected.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input lfspt_pkg::t_cfg_idx idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lfspt_pkg::CFG_RESOLUTION: res_q = {33'd0, val[30:0]};
            lfspt_pkg::CFG_ROT_W:      qw = 64'($signed(val));
            lfspt_pkg::CFG_ROT_X:      qx = 64'($signed(val));
            lfspt_pkg::CFG_ROT_Y:      qy = 64'($signed(val));
            lfspt_pkg::CFG_ROT_Z:      qz = 64'($signed(val));
            lfspt_pkg::CFG_SHIFT_X:    sh_x = 64'($signed(val));
            lfspt_pkg::CFG_SHIFT_Y:    sh_y = 64'($signed(val));
            default:                   sh_z = 64'($signed(val));
        endcase
    endtask

    task automatic set_all(input logic [31:0] res, input logic [31:0] w, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z, input logic [31:0] tx,
                           input logic [31:0] ty, input logic [31:0] tz);
        write_reg(lfspt_pkg::CFG_RESOLUTION, res);
        write_reg(lfspt_pkg::CFG_ROT_W, w);
        write_reg(lfspt_pkg::CFG_ROT_X, x);
        write_reg(lfspt_pkg::CFG_ROT_Y, y);
        write_reg(lfspt_pkg::CFG_ROT_Z, z);
        write_reg(lfspt_pkg::CFG_SHIFT_X, tx);
        write_reg(lfspt_pkg::CFG_SHIFT_Y, ty);
        write_reg(lfspt_pkg::CFG_SHIFT_Z, tz);
    endtask

    // mostly lidar-like ranges, sometimes full 32-bit values
    function automatic lfspt_pkg::t_coord rand_coord();
        case ($urandom_range(0, 5))
            0:       rand_coord = lfspt_pkg::t_coord'($urandom);
            1:       rand_coord = lfspt_pkg::t_coord'($signed($urandom_range(0, 40000))
                                                      - 20000);
            default: rand_coord = lfspt_pkg::t_coord'($signed($urandom_range(0, 8000000))
                                                      - 4000000);
        endcase
    endfunction

    task automatic add_random(input int n);
        repeat (n) enqueue_point('{rand_coord(), rand_coord(), rand_coord()});
    endtask

    initial begin
        n_errors = 0;
        hold_off_req = 0;
        sender_pause = 0;
        i_cfg_we = 1'b0;
        i_cfg_idx = lfspt_pkg::CFG_RESOLUTION;
        i_cfg_data = '0;
        res_q = 64'(lfspt_pkg::RESOLUTION_RST);
        qw = 64'(lfspt_pkg::ROT_W_RST);
        qx = 0; qy = 0; qz = 0;
        sh_x = 0; sh_y = 0; sh_z = 0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, field extremes, origin, short and long beams
        enqueue_point('{32'sd0, 32'sd0, 32'sd0});
        enqueue_point('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
        enqueue_point('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
        enqueue_point('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0});
        enqueue_point('{32'sd1, 32'sd0, 32'sd0});
        enqueue_point('{-32'sd3, 32'sd5, -32'sd7});
        enqueue_point('{32'sd26213, 32'sd0, 32'sd0});
        enqueue_point('{32'sd26214, 32'sd0, 32'sd0});
        enqueue_point('{32'sd655360, -32'sd327680, 32'sd65536});
        enqueue_point('{32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF});
        wait_drained();

        // zero resolution, 90 degree rotation about z, saturating shifts
        set_all(32'd0, 32'h2D41_3CCD, 32'd0, 32'd0, 32'h2D41_3CCD,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_5270);
        enqueue_point('{32'sd0, 32'sd0, 32'sd0});
        enqueue_point('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd12345});
        add_random(8);
        wait_drained();

        // extreme quaternion (not unit, clamped matrix), max resolution
        set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
        enqueue_point('{32'sd0, 32'sd0, 32'sd0});
        add_random(6);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        set_all(32'd13107, 32'h4000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_5270);
        add_random(150);
        hold_off_req = 1;
        while (!hold_done) @(posedge i_clk);
        hold_off_req = 0;
        wait_drained();

        // random settings; the sender pauses until drained between phases
        for (int ph = 0; ph < 6; ph++) begin
            set_all($urandom_range(0, 200000), $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
            if (ph % 2 == 0) begin
                // near-unit quaternion about a random axis
                write_reg(lfspt_pkg::CFG_ROT_W, 32'h3000_0000 + $urandom_range(0, 32'h0FFF_FFFF));
                write_reg(lfspt_pkg::CFG_ROT_X,
                          $urandom_range(0, 32'h1000_0000) - 32'h0800_0000);
                write_reg(lfspt_pkg::CFG_ROT_Y,
                          $urandom_range(0, 32'h1000_0000) - 32'h0800_0000);
                write_reg(lfspt_pkg::CFG_ROT_Z,
                          $urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
                write_reg(lfspt_pkg::CFG_SHIFT_X,
                          $urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
                write_reg(lfspt_pkg::CFG_SHIFT_Y,
                          $urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
            end
            add_random(120);
            if (ph == 3) begin
                // stop offering mid-stream until every owed result is out
                repeat (40) @(posedge i_clk);
                sender_pause = 1;
                while (world_expected.size() > 0 || i_valid) @(posedge i_clk);
                sender_pause = 0;
            end
            wait_drained();
        end

        if (n_errors == 0 && world_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+design
design/lfspt_pkg.sv
design/lidar_free_space_point_transform.sv
verif/tb_lidar_free_space_point_transform.sv
